>>> rtl/lce_pkg.sv
`timescale 1ns / 1ps

package lce_pkg;

  localparam int DEF_MAX_TAPS    = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int SUM_BITS      = 37;
  localparam int NUM_TAPS_BITS = 6;
  localparam int TAP_IDX_BITS  = 5;
  localparam int CMD_BITS      = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

>>> rtl/lce_mac.sv
`timescale 1ns / 1ps

module lce_mac import lce_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] a_i,
  input  logic signed [SAMPLE_BITS-1:0] b_i,
  output logic signed [SUM_BITS-1:0]    acc_o,
  output logic                          busy_o
);

  localparam int PW = 2 * SAMPLE_BITS;

  logic signed [PW-1:0]       prod_q;
  logic                       prod_vld_q;
  logic signed [SUM_BITS-1:0] acc_q;
  logic signed [SUM_BITS-1:0] prod_ext;

  // sign extend or wrap the product to the accumulator width (sum is mod 2^SUM_BITS)
  assign prod_ext = SUM_BITS'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= PW'(a_i) * PW'(b_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.en;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + prod_ext;
      end
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

>>> rtl/linear_convolution_engine.sv
`timescale 1ns / 1ps
// FIR convolution engine, one shared multiply-accumulate unit.
// Input channel (in_valid_i/in_ready_o) carries cmd_i, tap_index_i, value_i.
//   Load item: writes one coefficient in the accept cycle, no result.
//   Sample item: pushes the sample into the history, gives one sum_o.
//   Flush item: gives num_taps results, the tail outputs and then a zero
//   result with last_o set; the history is cleared afterwards.
// Output channel (out_valid_o/out_ready_i) carries sum_o and last_o from an
// output register.
// Each result takes n - k multiply terms through the single MAC (n active taps,
// k the flush step, 0 for a sample); each term passes the read registers, the
// product register and the accumulator, and the sum then loads the output
// register. The next item is taken once the block is back in idle. A flush item
// runs steps k = 1..n-1 this way, plus the final result. A load item leaves the
// block idle. in_ready_o is high only while no item is in work.
// If the receiver stalls, the next result waits in the sequencer until the
// output register frees; no result is dropped.
// Reset clears the config to one tap, all coefficients and the history (via valid
// bits and a fill count); the block is ready in the first cycle after reset. The
// user must set num_taps (cfg_wdata_i) at cfg_we_i only while idle; not enforced.

module linear_convolution_engine import lce_pkg::*; #(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [NUM_TAPS_BITS-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [CMD_BITS-1:0]           cmd_i,
  input  logic [TAP_IDX_BITS-1:0]       tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SUM_BITS-1:0]    sum_o,
  output logic                          last_o
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  state_e state_q, state_d;

  logic [NUM_TAPS_BITS-1:0] num_taps_q;
  logic [CW-1:0]            n_act;

  logic [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]    coef_vld_q;

  logic [AW-1:0] head_q, head_nxt;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] k_q, k_nxt;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] m_q;
  logic [AW-1:0] c_addr_q, h_addr_q;
  logic          flush_q, last_pend_q;

  logic                   rd_vld_q, coef_ok_q, smp_ok_q;
  logic [SAMPLE_BITS-1:0] coef_rd_q, smp_rd_q;

  logic          accept, coef_we, issue, out_load, drained, step_last;
  cmd_e          cmd;
  mac_ctrl_t     mac_ctrl;
  logic signed [SUM_BITS-1:0] acc;
  logic          mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_a, mac_b;

  logic                       out_vld_q, out_last_q;
  logic signed [SUM_BITS-1:0] out_sum_q;

  // zero taps acts as one, too many acts as MAX_TAPS
  always_comb begin
    if (num_taps_q == '0) begin
      n_act = CW'(1);
    end else if (int'(num_taps_q) > MAX_TAPS) begin
      n_act = CW'(MAX_TAPS);
    end else begin
      n_act = CW'(num_taps_q);
    end
  end

  assign cmd       = cmd_e'(cmd_i);
  assign accept    = in_valid_i && in_ready_o;
  assign coef_we   = accept && (cmd == CMD_LOAD) && (int'(tap_index_i) < MAX_TAPS);
  assign head_nxt  = (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);
  assign k_nxt     = k_q + CW'(1);
  assign drained   = (rem_q == '0) && !rd_vld_q && !mac_busy;
  assign step_last = (k_nxt == n_act);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_SAMPLE: state_d = ST_RUN;
            CMD_FLUSH:  state_d = (n_act == CW'(1)) ? ST_EMIT : ST_RUN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (drained) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (last_pend_q || !flush_q) begin
            state_d = ST_IDLE;
          end else if (step_last) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    issue        = 1'b0;
    out_load     = 1'b0;
    mac_ctrl.en  = rd_vld_q;
    mac_ctrl.clr = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        mac_ctrl.clr = in_valid_i;
      end
      ST_RUN: begin
        issue = (rem_q != '0);
      end
      ST_EMIT: begin
        out_load     = !out_vld_q || out_ready_i;
        mac_ctrl.clr = out_load;
      end
      default: ;
    endcase
  end

  assign mac_a = coef_ok_q ? coef_rd_q : '0;
  assign mac_b = smp_ok_q ? smp_rd_q : '0;

  lce_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // memories
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[AW'(tap_index_i)] <= value_i;
    end
    if (issue) begin
      coef_rd_q <= coef_mem[c_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CMD_SAMPLE)) begin
      hist_mem[head_nxt] <= value_i;
    end
    if (issue) begin
      smp_rd_q <= hist_mem[h_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      coef_ok_q <= coef_vld_q[c_addr_q];
      smp_ok_q  <= (m_q < cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q  <= last_pend_q ? '0 : acc;
      out_last_q <= last_pend_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_taps_q  <= NUM_TAPS_BITS'(1);
      coef_vld_q  <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      rem_q       <= '0;
      m_q         <= '0;
      c_addr_q    <= '0;
      h_addr_q    <= '0;
      flush_q     <= 1'b0;
      last_pend_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_we_i) begin
        num_taps_q <= cfg_wdata_i;
      end
      if (coef_we) begin
        coef_vld_q[AW'(tap_index_i)] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      if (accept && (cmd == CMD_SAMPLE)) begin
        head_q   <= head_nxt;
        if (cnt_q != CW'(MAX_TAPS)) begin
          cnt_q <= cnt_q + CW'(1);
        end
        flush_q  <= 1'b0;
        k_q      <= '0;
        rem_q    <= n_act;
        m_q      <= '0;
        c_addr_q <= '0;
        h_addr_q <= head_nxt;
      end else if (accept && (cmd == CMD_FLUSH)) begin
        flush_q     <= 1'b1;
        k_q         <= CW'(1);
        rem_q       <= n_act - CW'(1);
        m_q         <= '0;
        c_addr_q    <= AW'(1);
        h_addr_q    <= head_q;
        last_pend_q <= (n_act == CW'(1));
      end

      // term m of flush step k pairs coefficient m+k with the sample m steps back
      if (issue) begin
        rem_q    <= rem_q - CW'(1);
        m_q      <= m_q + CW'(1);
        c_addr_q <= c_addr_q + AW'(1);
        h_addr_q <= (h_addr_q == '0) ? AW'(MAX_TAPS - 1) : h_addr_q - AW'(1);
      end

      if (out_load && flush_q) begin
        if (last_pend_q) begin
          last_pend_q <= 1'b0;
          cnt_q       <= '0;
        end else begin
          k_q <= k_nxt;
          if (step_last) begin
            last_pend_q <= 1'b1;
          end else begin
            rem_q    <= n_act - k_nxt;
            m_q      <= '0;
            c_addr_q <= AW'(k_nxt);
            h_addr_q <= head_q;
          end
        end
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign sum_o       = out_sum_q;
  assign last_o      = out_last_q;

endmodule

>>> rtl/lce_checker.sv
`timescale 1ns / 1ps

module lce_checker import lce_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [CMD_BITS-1:0]           cmd_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SUM_BITS-1:0]    sum_o,
  input logic                          last_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sum_o) && $stable(last_o))
    else $error("stalled result changed");

  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> sum_o == '0)
    else $error("final flush result not zero");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == CMD_SAMPLE) |=> !in_ready_o)
    else $error("ready right after a sample item");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == CMD_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load item produced a result");

endmodule

bind linear_convolution_engine lce_checker u_lce_checker (.*);
